@@ src/tone_cadence_matcher_top_macros.svh @@
// Assertion macros for the checked module, tcm_back.
// Both expect a signal named clk, and TCM_ASSERT also rst_n, in the module that uses them.
`ifndef TONE_CADENCE_MATCHER_TOP_MACROS_SVH
`define TONE_CADENCE_MATCHER_TOP_MACROS_SVH

// Check outside reset.
`define TCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check at every edge, reset included.
`define TCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/tcm_pkg.sv @@
`timescale 1ns / 1ps
package tcm_pkg;

  // Classified input command, carried through the queue
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_TONE   = 2'd1,
    CMD_ABSENT = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } q_item_t;

  // Input verdict codes
  localparam logic [1:0] VERDICT_TONE   = 2'd1;
  localparam logic [1:0] VERDICT_ABSENT = 2'd2;

  // Result codes
  typedef enum logic [1:0] {
    OUT_NONE    = 2'd0,
    OUT_DETECT  = 2'd1,
    OUT_RESTART = 2'd2
  } outcome_t;

  // Register indexes
  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_TOLERANCE = 3'd1,
    REG_TONE_LIM  = 3'd2,
    REG_GAP_LIM   = 3'd3,
    REG_SILENCE   = 3'd4,
    REG_REQUIRED  = 3'd5,
    REG_PATTERN   = 3'd6,
    REG_PMIN      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]  match_mode;
    logic [15:0] tolerance;
    logic [31:0] tone_limits;
    logic [31:0] gap_limits;
    logic [15:0] silence_limit;
    logic [4:0]  required_periods;
    logic [63:0] pattern_words;
    logic [3:0]  pattern_min_index;
  } cfg_t;

  localparam logic [3:0] FAIL_MAX = 4'd15;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BS_IDLE = 2'd0,
    BS_ADDR = 2'd1,
    BS_EVAL = 2'd2
  } back_state_t;

endpackage

@@ src/tone_cadence_matcher_top.sv @@
`timescale 1ns / 1ps
// Channel   Handshake          Payload
// in_       in_valid/in_stall  in_kind, in_verdict
// out_      out_valid/out_stall out_outcome, out_filter_reset
// cfg_      cfg_we             cfg_index, cfg_data (no read-back)
//
// An item is registered in a two-entry queue before it reaches the back end.
// Most items are handled as they are popped; a tone end that triggers a match
// walks the period stores with an address state and an evaluate state per record
// read (registered RAM read): three records for the fixed form, required_periods
// (at least two) for the looped form, three or six for the unrolled form.
// Reset is synchronous, active low; the period stores read as zero until written.
// in_stall rises while the queue is full; out_stall holds a valid result register
// and the back end then stops taking queued items.
module tone_cadence_matcher_top #(
  parameter int MAX_PERIODS  = 16,
  parameter int MAX_FAILURES = 8,
  parameter int LENGTH_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [1:0]  in_verdict,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_outcome,
  output logic        out_filter_reset,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  tcm_pkg::cfg_t    cfg_r;
  logic             q_valid, q_pop;
  tcm_pkg::q_item_t q_item;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match_mode        <= 3'd0;
      cfg_r.tolerance         <= 16'd3;
      cfg_r.tone_limits       <= 32'd0;
      cfg_r.gap_limits        <= 32'd0;
      cfg_r.silence_limit     <= 16'hFFFF;
      cfg_r.required_periods  <= 5'd2;
      cfg_r.pattern_words     <= 64'd0;
      cfg_r.pattern_min_index <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        tcm_pkg::REG_MODE:      cfg_r.match_mode        <= cfg_data[2:0];
        tcm_pkg::REG_TOLERANCE: cfg_r.tolerance         <= cfg_data[15:0];
        tcm_pkg::REG_TONE_LIM:  cfg_r.tone_limits       <= cfg_data[31:0];
        tcm_pkg::REG_GAP_LIM:   cfg_r.gap_limits        <= cfg_data[31:0];
        tcm_pkg::REG_SILENCE:   cfg_r.silence_limit     <= cfg_data[15:0];
        tcm_pkg::REG_REQUIRED:  cfg_r.required_periods  <= cfg_data[4:0];
        tcm_pkg::REG_PATTERN:   cfg_r.pattern_words     <= cfg_data;
        tcm_pkg::REG_PMIN:      cfg_r.pattern_min_index <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  tcm_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_verdict(in_verdict),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  tcm_back #(
    .MAX_PERIODS(MAX_PERIODS), .MAX_FAILURES(MAX_FAILURES), .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_outcome(out_outcome), .out_filter_reset(out_filter_reset)
  );

endmodule

@@ src/tcm_ram.sv @@
`timescale 1ns / 1ps
module tcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/tcm_front.sv @@
`timescale 1ns / 1ps
module tcm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [1:0]        in_verdict,
  output logic              q_valid,
  output tcm_pkg::q_item_t  q_item,
  input  logic              q_pop
);

  tcm_pkg::q_item_t slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push;
  tcm_pkg::q_item_t item_in;

  // Classify the incoming transfer
  always_comb begin
    if (in_kind) begin
      item_in.cmd = tcm_pkg::CMD_CLEAR;
    end else begin
      case (in_verdict)
        tcm_pkg::VERDICT_TONE:   item_in.cmd = tcm_pkg::CMD_TONE;
        tcm_pkg::VERDICT_ABSENT: item_in.cmd = tcm_pkg::CMD_ABSENT;
        default:                 item_in.cmd = tcm_pkg::CMD_NONE;
      endcase
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold queued items
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

@@ src/tcm_back.sv @@
`timescale 1ns / 1ps
`include "tone_cadence_matcher_top_macros.svh"
module tcm_back #(
  parameter int MAX_PERIODS  = 16,
  parameter int MAX_FAILURES = 8,
  parameter int LENGTH_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tcm_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  tcm_pkg::q_item_t q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_outcome,
  output logic             out_filter_reset
);

  localparam int LW = LENGTH_BITS;
  localparam int PW = $clog2(MAX_PERIODS);
  localparam int CW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
  localparam int XW = PW + 6;
  localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};

  function automatic logic [CW-1:0] absdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction

  tcm_pkg::back_state_t state_r, state_nxt;
  logic                 in_tone_r, in_tone_nxt;
  logic [LW-1:0]        run_r, run_nxt;
  logic [PW-1:0]        pidx_r, pidx_nxt;
  logic [3:0]           fail_r, fail_nxt;
  logic [MAX_PERIODS-1:0] tvld_r, gvld_r;
  logic                 tvld_q, gvld_q;
  logic [PW-1:0]        last_r, last_nxt;
  logic [PW-1:0]        k_r, k_nxt;
  logic                 ok_r, ok_nxt, one_r, one_nxt, two_r, two_nxt;
  logic [CW-1:0]        g_r, g_nxt, t_r, t_nxt, gp_r, gp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_outcome_r, out_outcome_nxt;
  logic                 out_fr_r, out_fr_nxt;

  logic                 t_we, g_we;
  logic [PW-1:0]        t_waddr, g_waddr, rd_addr;
  logic [LW-1:0]        t_wdata, g_wdata, t_rdata, g_rdata;

  logic                 fixed_m, looped_m, can_go, go_match, last_step, is_ref, hit;
  logic [XW-1:0]        cyc_x, loop_end_x, k_x, final_k_x, ref_x, newp_x;
  logic [PW-1:0]        ref_a;
  logic [CW-1:0]        tol_c, tq, gq, p0, p1, p2, p3;
  logic [LW-1:0]        run_inc;

  tcm_ram #(.WIDTH(LW), .DEPTH(MAX_PERIODS)) u_tone_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(rd_addr), .rdata(t_rdata)
  );

  tcm_ram #(.WIDTH(LW), .DEPTH(MAX_PERIODS)) u_gap_ram (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(rd_addr), .rdata(g_rdata)
  );

  // Decode mode, tolerance floor and match walk bounds
  always_comb begin
    fixed_m    = cfg.match_mode[0];
    looped_m   = !cfg.match_mode[0] && cfg.match_mode[1];
    tol_c      = (cfg.tolerance <= 16'd2) ? CW'(16'd3) : CW'(cfg.tolerance);
    p0         = CW'(cfg.pattern_words[15:0]);
    p1         = CW'(cfg.pattern_words[31:16]);
    p2         = CW'(cfg.pattern_words[47:32]);
    p3         = CW'(cfg.pattern_words[63:48]);
    cyc_x      = XW'(cfg.required_periods);
    loop_end_x = (cyc_x >= XW'(2)) ? cyc_x - XW'(1) : XW'(1);
    k_x        = XW'(k_r);
    is_ref     = (k_x == loop_end_x);
    if (fixed_m) begin
      final_k_x = XW'(2);
    end else if (looped_m) begin
      final_k_x = loop_end_x;
    end else begin
      final_k_x = (last_r > PW'(5)) ? XW'(5) : XW'(2);
    end
    last_step = (k_x == final_k_x);
    ref_x     = XW'(last_r) + XW'(1) - cyc_x;
    ref_a     = (ref_x >= XW'(MAX_PERIODS)) ? '0 : ref_x[PW-1:0];
    if (fixed_m) begin
      rd_addr = k_r;
    end else if (looped_m && is_ref) begin
      rd_addr = ref_a;
    end else if (k_r > last_r) begin
      // Step back round the ring past index zero
      rd_addr = PW'(XW'(last_r) + XW'(MAX_PERIODS) - k_x);
    end else begin
      rd_addr = last_r - k_r;
    end
    tq = CW'(tvld_q ? t_rdata : '0);
    gq = CW'(gvld_q ? g_rdata : '0);
  end

  // Classify the popped item against the run state
  always_comb begin
    can_go   = q_valid && (!out_valid_r || !out_stall);
    q_pop    = (state_r == tcm_pkg::BS_IDLE) && can_go;
    run_inc  = (run_r != LEN_MAX) ? run_r + LW'(1) : run_r;
    newp_x   = XW'(pidx_r) + XW'(1);
    go_match = q_pop && (q_item.cmd == tcm_pkg::CMD_ABSENT) && in_tone_r
               && (pidx_r != '0) && (newp_x >= cyc_x)
               && (fixed_m || looped_m || (pidx_r > PW'(1)));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcm_pkg::BS_IDLE: if (go_match) state_nxt = tcm_pkg::BS_ADDR;
      tcm_pkg::BS_ADDR: state_nxt = tcm_pkg::BS_EVAL;
      tcm_pkg::BS_EVAL: state_nxt = last_step ? tcm_pkg::BS_IDLE : tcm_pkg::BS_ADDR;
      default:          state_nxt = tcm_pkg::BS_IDLE;
    endcase
  end

  // Datapath and result register
  always_comb begin
    in_tone_nxt     = in_tone_r;
    run_nxt         = run_r;
    pidx_nxt        = pidx_r;
    fail_nxt        = fail_r;
    last_nxt        = last_r;
    k_nxt           = k_r;
    ok_nxt          = ok_r;
    one_nxt         = one_r;
    two_nxt         = two_r;
    g_nxt           = g_r;
    t_nxt           = t_r;
    gp_nxt          = gp_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_outcome_nxt = out_outcome_r;
    out_fr_nxt      = out_fr_r;
    t_we            = 1'b0;
    t_waddr         = pidx_r;
    t_wdata         = run_r;
    g_we            = 1'b0;
    g_waddr         = pidx_r;
    g_wdata         = run_r;
    hit             = 1'b0;

    case (state_r)
      tcm_pkg::BS_IDLE: begin
        if (q_pop) begin
          out_outcome_nxt = tcm_pkg::OUT_NONE;
          out_fr_nxt      = 1'b0;
          case (q_item.cmd)
            tcm_pkg::CMD_CLEAR: begin
              in_tone_nxt = 1'b0;
              run_nxt     = '0;
              pidx_nxt    = '0;
              fail_nxt    = '0;
              out_fr_nxt  = 1'b1;
            end
            tcm_pkg::CMD_TONE: begin
              if (cfg.match_mode[2]) out_outcome_nxt = tcm_pkg::OUT_DETECT;
              if (in_tone_r) begin
                if (!fixed_m && (cfg.tone_limits[31:16] == 16'd0)) begin
                  in_tone_nxt     = 1'b0;
                  run_nxt         = '0;
                  pidx_nxt        = '0;
                  out_outcome_nxt = tcm_pkg::OUT_DETECT;
                end else begin
                  run_nxt = run_inc;
                end
              end else begin
                in_tone_nxt = 1'b1;
                g_we        = 1'b1;
                run_nxt     = '0;
              end
            end
            tcm_pkg::CMD_ABSENT: begin
              if (!in_tone_r) begin
                run_nxt = run_inc;
                if (CW'(run_inc) > CW'(cfg.silence_limit)) pidx_nxt = '0;
              end else begin
                t_we     = 1'b1;
                last_nxt = pidx_r;
                if (pidx_r == '0) begin
                  if (fail_r != tcm_pkg::FAIL_MAX) fail_nxt = fail_r + 4'd1;
                end
                pidx_nxt    = (newp_x > XW'(MAX_PERIODS - 1)) ? '0 : newp_x[PW-1:0];
                run_nxt     = '0;
                in_tone_nxt = 1'b0;
              end
            end
            default: ;
          endcase
          if (go_match) begin
            // Start the record walk
            k_nxt   = '0;
            ok_nxt  = fixed_m ? (PW'(cfg.pattern_min_index) <= pidx_r
                                 && XW'(cfg.pattern_min_index) < XW'(MAX_PERIODS)
                                 || XW'(cfg.pattern_min_index) <= XW'(pidx_r)) : 1'b1;
            one_nxt = 1'b1;
            two_nxt = 1'b1;
          end else begin
            out_valid_nxt = 1'b1;
            if (fail_nxt > 4'(MAX_FAILURES)) begin
              in_tone_nxt     = 1'b0;
              run_nxt         = '0;
              pidx_nxt        = '0;
              out_fr_nxt      = 1'b1;
              out_outcome_nxt = tcm_pkg::OUT_RESTART;
            end
          end
        end
      end
      tcm_pkg::BS_EVAL: begin
        if (fixed_m) begin
          if (k_r == PW'(0)) begin
            ok_nxt = ok_r && (absdiff(tq, p0) <= tol_c);
          end else if (k_r == PW'(1)) begin
            ok_nxt = ok_r && (absdiff(gq, p1) <= tol_c) && (absdiff(tq, p2) <= tol_c);
          end else begin
            ok_nxt = ok_r && (absdiff(gq, p3) <= tol_c);
          end
        end else if (looped_m) begin
          if (k_r == PW'(0)) begin
            g_nxt  = gq;
            t_nxt  = tq;
            ok_nxt = ok_r && (gq >= CW'(cfg.gap_limits[15:0]))
                     && (gq <= CW'(cfg.gap_limits[31:16]))
                     && (tq >= CW'(cfg.tone_limits[15:0]))
                     && (tq <= CW'(cfg.tone_limits[31:16]));
          end else if (is_ref) begin
            ok_nxt = ok_r && !(g_r > gq) && (absdiff(t_r, tq) < tol_c);
          end else begin
            ok_nxt = ok_r && (absdiff(g_r, gq) < tol_c);
          end
        end else begin
          if (k_r == PW'(0)) begin
            g_nxt  = gq;
            t_nxt  = tq;
            ok_nxt = ok_r && (gq >= CW'(cfg.gap_limits[15:0]))
                     && (gq <= CW'(cfg.gap_limits[31:16]))
                     && (tq >= CW'(cfg.tone_limits[15:0]))
                     && (tq <= CW'(cfg.tone_limits[31:16]));
          end else if (k_r == PW'(1)) begin
            gp_nxt  = gq;
            one_nxt = one_r && (absdiff(g_r, gq) < tol_c) && (absdiff(t_r, tq) < tol_c);
          end else if (k_r == PW'(2) || k_r == PW'(4)) begin
            if (k_r == PW'(2)) begin
              one_nxt = one_r && (absdiff(g_r, gq) < tol_c) && (absdiff(t_r, tq) < tol_c);
            end
            two_nxt = two_r && (absdiff(g_r, gq) < tol_c) && (absdiff(t_r, tq) < tol_c);
          end else begin
            two_nxt = two_r && (absdiff(gp_r, gq) < tol_c);
          end
        end
        k_nxt = k_r + PW'(1);
        if (last_step) begin
          if (fixed_m || looped_m) begin
            hit = ok_nxt;
          end else begin
            hit = ok_nxt && (one_nxt || ((last_r > PW'(5)) && two_nxt));
          end
          out_valid_nxt   = 1'b1;
          out_outcome_nxt = tcm_pkg::OUT_NONE;
          out_fr_nxt      = 1'b0;
          if (hit) begin
            in_tone_nxt     = 1'b0;
            run_nxt         = '0;
            pidx_nxt        = '0;
            out_fr_nxt      = 1'b1;
            out_outcome_nxt = tcm_pkg::OUT_DETECT;
          end
          if (fail_r > 4'(MAX_FAILURES)) begin
            in_tone_nxt     = 1'b0;
            run_nxt         = '0;
            pidx_nxt        = '0;
            out_fr_nxt      = 1'b1;
            out_outcome_nxt = tcm_pkg::OUT_RESTART;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers and store valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcm_pkg::BS_IDLE;
      in_tone_r   <= 1'b0;
      run_r       <= '0;
      pidx_r      <= '0;
      fail_r      <= '0;
      tvld_r      <= '0;
      gvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tone_r   <= in_tone_nxt;
      run_r       <= run_nxt;
      pidx_r      <= pidx_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
      if (t_we) tvld_r[t_waddr] <= 1'b1;
      if (g_we) gvld_r[g_waddr] <= 1'b1;
    end
  end

  // Walk and result payload
  always_ff @(posedge clk) begin
    tvld_q        <= tvld_r[rd_addr];
    gvld_q        <= gvld_r[rd_addr];
    last_r        <= last_nxt;
    k_r           <= k_nxt;
    ok_r          <= ok_nxt;
    one_r         <= one_nxt;
    two_r         <= two_nxt;
    g_r           <= g_nxt;
    t_r           <= t_nxt;
    gp_r          <= gp_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_fr_r      <= out_fr_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = out_outcome_r;
  assign out_filter_reset = out_fr_r;

  `TCM_ASSERT(a_walk_slot_free, (state_r != tcm_pkg::BS_IDLE) |-> !out_valid_r, "result slot busy during record walk")
  `TCM_ASSERT(a_pidx_range, XW'(pidx_r) < XW'(MAX_PERIODS), "period index outside ring")
  `TCM_ASSERT(a_fail_cleared, (fail_r > 4'(MAX_FAILURES)) |-> (!in_tone_r && run_r == '0), "run state kept after too many failures")
  `TCM_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (!out_valid_r && state_r == tcm_pkg::BS_IDLE), "reset did not clear back end")

endmodule

@@ tb/tone_cadence_matcher_top_test.sv @@
`timescale 1ns / 1ps
module tone_cadence_matcher_top_test;

  localparam int NPER = 16;
  localparam int NFAIL = 8;
  localparam logic [15:0] RUN_MAX = 16'hFFFF;
  localparam int WATCHDOG = 20000;
  localparam logic [1:0] V_NEITHER = 2'd0;
  localparam logic [1:0] V_CODE3 = 2'd3;

  typedef struct {
    logic       kind;
    logic [1:0] verdict;
  } tick_t;

  typedef struct {
    tcm_pkg::outcome_t outcome;
    logic              freset;
  } verdict_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  logic [1:0] in_verdict = 2'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_outcome;
  logic out_filter_reset;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = 3'd0;
  logic [63:0] cfg_data = 64'd0;

  tone_cadence_matcher_top dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Predictor state and its copy of the registers
  tcm_pkg::cfg_t cfg;
  logic        p_in_tone;
  logic [15:0] p_run;
  logic [4:0]  p_idx;
  logic [3:0]  p_fail;
  logic [15:0] p_tone [NPER];
  logic [15:0] p_gap [NPER];

  tick_t pending_ticks[$];
  verdict_out_t expected_verdicts[$];
  int n_errors = 0;
  int idle_cycles = 0;
  int hold_off = 0;

  function automatic int absdiff(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic int rix(int i);
    return ((i % NPER) + NPER) % NPER;
  endfunction

  function automatic bit in_range(int v, logic [31:0] lim);
    return v >= lim[15:0] && v <= lim[31:16];
  endfunction

  function automatic int patw(int k);
    return cfg.pattern_words[16*k +: 16];
  endfunction

  function automatic bit cad_fixed_ok(int last, int tol);
    if (cfg.pattern_min_index > last) return 0;
    if (absdiff(p_tone[0], patw(0)) > tol) return 0;
    if (absdiff(p_gap[1], patw(1)) > tol) return 0;
    if (absdiff(p_tone[1], patw(2)) > tol) return 0;
    if (absdiff(p_gap[2], patw(3)) > tol) return 0;
    return 1;
  endfunction

  function automatic bit cad_window_ok(int last, int tol);
    int cyc, g, t, rf;
    bit ok;
    cyc = cfg.required_periods;
    g = p_gap[rix(last)];
    t = p_tone[rix(last)];
    if (cyc >= 1 && cyc - 1 > last) return 0;
    ok = in_range(g, cfg.gap_limits) && in_range(t, cfg.tone_limits);
    for (int k = 1; k + 1 < cyc; k++)
      if (absdiff(g, p_gap[rix(last - k)]) >= tol) ok = 0;
    rf = rix(last + 1 - cyc);
    if (g > p_gap[rf]) return 0;
    if (absdiff(t, p_tone[rf]) >= tol) return 0;
    return ok;
  endfunction

  function automatic bit cad_period_ok(int last, int tol);
    int g, t, gp;
    bit one, two;
    if ((cfg.required_periods >= 1 && cfg.required_periods - 1 > last) || last <= 1)
      return 0;
    g = p_gap[rix(last)];
    if (!in_range(g, cfg.gap_limits)) return 0;
    t = p_tone[rix(last)];
    if (!in_range(t, cfg.tone_limits)) return 0;
    gp = p_gap[rix(last - 1)];
    one = absdiff(g, gp) < tol && absdiff(g, p_gap[rix(last - 2)]) < tol
      && absdiff(t, p_tone[rix(last - 1)]) < tol && absdiff(t, p_tone[rix(last - 2)]) < tol;
    two = last > 5 && absdiff(g, p_gap[rix(last - 2)]) < tol
      && absdiff(g, p_gap[rix(last - 4)]) < tol && absdiff(t, p_tone[rix(last - 2)]) < tol
      && absdiff(t, p_tone[rix(last - 4)]) < tol && absdiff(gp, p_gap[rix(last - 3)]) < tol
      && absdiff(gp, p_gap[rix(last - 5)]) < tol;
    return one || two;
  endfunction

  function automatic bit match_cadence(int last);
    int tol;
    tol = cfg.tolerance <= 2 ? 3 : cfg.tolerance;
    if (cfg.match_mode[0]) return cad_fixed_ok(last, tol);
    if (cfg.match_mode[1]) return cad_window_ok(last, tol);
    return cad_period_ok(last, tol);
  endfunction

  function automatic void drop_run();
    p_in_tone = 1'b0;
    p_run = '0;
    p_idx = '0;
  endfunction

  function automatic verdict_out_t track_cadence(tick_t tk);
    verdict_out_t r;
    int last;
    bit hit;
    r.outcome = tcm_pkg::OUT_NONE;
    r.freset = 1'b0;
    if (tk.kind) begin
      drop_run();
      p_fail = '0;
      r.freset = 1'b1;
      return r;
    end
    if (tk.verdict == tcm_pkg::VERDICT_TONE) begin
      if (cfg.match_mode[2]) r.outcome = tcm_pkg::OUT_DETECT;
      if (p_in_tone) begin
        if (!cfg.match_mode[0] && cfg.tone_limits[31:16] == 0) begin
          drop_run();
          r.outcome = tcm_pkg::OUT_DETECT;
        end else if (p_run < RUN_MAX) begin
          p_run++;
        end
      end else begin
        p_in_tone = 1'b1;
        p_gap[rix(p_idx)] = p_run;
        p_run = '0;
      end
    end else if (tk.verdict == tcm_pkg::VERDICT_ABSENT) begin
      if (!p_in_tone) begin
        if (p_run < RUN_MAX) p_run++;
        if (p_run > cfg.silence_limit) p_idx = '0;
      end else begin
        last = rix(p_idx);
        hit = 1'b0;
        p_tone[last] = p_run;
        p_idx = 5'(last + 1);
        if (last == 0) begin
          if (p_fail < tcm_pkg::FAIL_MAX) p_fail++;
        end else if (p_idx >= cfg.required_periods) begin
          hit = match_cadence(p_idx - 1);
        end
        if (p_idx > NPER - 1) p_idx = '0;
        p_run = '0;
        p_in_tone = 1'b0;
        if (hit) begin
          drop_run();
          r.freset = 1'b1;
          r.outcome = tcm_pkg::OUT_DETECT;
        end
      end
    end
    if (p_fail > NFAIL) begin
      drop_run();
      r.freset = 1'b1;
      r.outcome = tcm_pkg::OUT_RESTART;
    end
    return r;
  endfunction

  // Driver: offer queued ticks with random gaps; predict on each transfer
  int tx_gap = 0;
  always @(posedge clk) begin
    tick_t tk;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tk.kind = in_kind;
        tk.verdict = in_verdict;
        expected_verdicts.push_back(track_cadence(tk));
        void'(pending_ticks.pop_front());
        tx_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
        in_valid <= 1'b0;
      end else if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
        end else if (pending_ticks.size() > 0) begin
          in_valid <= 1'b1;
          in_kind <= pending_ticks[0].kind;
          in_verdict <= pending_ticks[0].verdict;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  int rx_gap = 0;
  always @(posedge clk) begin
    verdict_out_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result outcome=%0d filter_reset=%0d", out_outcome,
            out_filter_reset);
          n_errors++;
        end else begin
          e = expected_verdicts.pop_front();
          if (out_outcome !== e.outcome) begin
            $error("outcome: expected %0d, got %0d", e.outcome, out_outcome);
            n_errors++;
          end
          if (out_filter_reset !== e.freset) begin
            $error("filter_reset: expected %0d, got %0d", e.freset, out_filter_reset);
            n_errors++;
          end
        end
        rx_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
      end
      // Hold off a long stretch when asked, else stall for the drawn gap
      if (hold_off > 0) begin
        hold_off--;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off > 0)
      idle_cycles <= 0;
    else if (pending_ticks.size() > 0 || expected_verdicts.size() > 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tone_cadence_matcher_top_test: errors");
      $finish;
    end
  end

  task automatic write_reg(tcm_pkg::reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tcm_pkg::REG_MODE: cfg.match_mode = val[2:0];
      tcm_pkg::REG_TOLERANCE: cfg.tolerance = val[15:0];
      tcm_pkg::REG_TONE_LIM: cfg.tone_limits = val[31:0];
      tcm_pkg::REG_GAP_LIM: cfg.gap_limits = val[31:0];
      tcm_pkg::REG_SILENCE: cfg.silence_limit = val[15:0];
      tcm_pkg::REG_REQUIRED: cfg.required_periods = val[4:0];
      tcm_pkg::REG_PATTERN: cfg.pattern_words = val;
      tcm_pkg::REG_PMIN: cfg.pattern_min_index = val[3:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() > 0 || expected_verdicts.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic void push_tick(logic kind, logic [1:0] verdict);
    tick_t tk;
    tk.kind = kind;
    tk.verdict = verdict;
    pending_ticks.push_back(tk);
  endfunction

  // Queue periods of roughly the given tone and gap lengths with jitter
  function automatic void push_cadence(int periods, int tone_len, int gap_len, int jit);
    for (int p = 0; p < periods; p++) begin
      int tl, gl;
      tl = tone_len + $urandom_range(0, jit);
      gl = gap_len + $urandom_range(0, jit);
      for (int i = 0; i <= tl; i++) push_tick(1'b0, tcm_pkg::VERDICT_TONE);
      for (int i = 0; i < gl; i++) begin
        push_tick(1'b0, tcm_pkg::VERDICT_ABSENT);
        if ($urandom_range(0, 30) == 0)
          push_tick(1'b0, $urandom_range(0, 1) ? V_NEITHER : V_CODE3);
      end
    end
  endfunction

  task automatic random_config();
    write_reg(tcm_pkg::REG_MODE, 64'($urandom_range(0, 7)));
    write_reg(tcm_pkg::REG_TOLERANCE,
      $urandom_range(0, 9) == 0 ? 64'hFFFF : 64'($urandom_range(0, 4)));
    write_reg(tcm_pkg::REG_TONE_LIM,
      64'({$urandom_range(0, 4) == 0 ? 16'd0 : 16'($urandom_range(3, 9)),
      16'($urandom_range(0, 3))}));
    write_reg(tcm_pkg::REG_GAP_LIM,
      64'({16'($urandom_range(2, 12)), 16'($urandom_range(0, 3))}));
    write_reg(tcm_pkg::REG_SILENCE,
      $urandom_range(0, 4) == 0 ? 64'hFFFF : 64'($urandom_range(0, 12)));
    write_reg(tcm_pkg::REG_REQUIRED, 64'($urandom_range(0, 17)));
    write_reg(tcm_pkg::REG_PATTERN, {16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
      16'($urandom_range(1, 6)), 16'($urandom_range(1, 6))});
    write_reg(tcm_pkg::REG_PMIN, 64'($urandom_range(0, 15)));
  endtask

  initial begin
    int total;
    cfg.match_mode = '0;
    cfg.tolerance = 16'd3;
    cfg.tone_limits = '0;
    cfg.gap_limits = '0;
    cfg.silence_limit = 16'hFFFF;
    cfg.required_periods = 5'd2;
    cfg.pattern_words = '0;
    cfg.pattern_min_index = 4'd2;
    p_fail = '0;
    drop_run();
    for (int i = 0; i < NPER; i++) begin
      p_tone[i] = '0;
      p_gap[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, no tone bound, neither and code three, clear
    push_tick(1'b0, V_NEITHER);
    push_tick(1'b0, V_CODE3);
    push_tick(1'b0, tcm_pkg::VERDICT_TONE);
    push_tick(1'b0, tcm_pkg::VERDICT_TONE);
    push_tick(1'b0, tcm_pkg::VERDICT_ABSENT);
    push_tick(1'b1, V_CODE3);
    push_tick(1'b1, V_NEITHER);
    wait_drained();
    // Failure count: many one-period cadences
    write_reg(tcm_pkg::REG_TONE_LIM, 64'h0000_0000_FFFF_0000);
    for (int i = 0; i < 11; i++) begin
      push_tick(1'b0, tcm_pkg::VERDICT_TONE);
      push_tick(1'b0, tcm_pkg::VERDICT_ABSENT);
    end
    push_tick(1'b1, V_NEITHER);
    wait_drained();

    // Pressure: receiver holds off while the sender keeps offering
    hold_off = 200;
    push_cadence(3, 2, 2, 0);
    wait_drained();

    // Extremes of the registers, including required_periods of zero and above
    write_reg(tcm_pkg::REG_MODE, 64'd2);
    write_reg(tcm_pkg::REG_REQUIRED, 64'd0);
    write_reg(tcm_pkg::REG_TOLERANCE, 64'd0);
    write_reg(tcm_pkg::REG_GAP_LIM, 64'h0000_0000_FFFF_0000);
    write_reg(tcm_pkg::REG_SILENCE, 64'd0);
    write_reg(tcm_pkg::REG_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(tcm_pkg::REG_PMIN, 64'd15);
    push_cadence(3, 2, 3, 1);
    wait_drained();
    write_reg(tcm_pkg::REG_REQUIRED, 64'd31);
    write_reg(tcm_pkg::REG_SILENCE, 64'hFFFF);
    write_reg(tcm_pkg::REG_MODE, 64'd7);
    write_reg(tcm_pkg::REG_PMIN, 64'd0);
    push_cadence(2, 1, 1, 0);
    push_tick(1'b1, V_NEITHER);
    wait_drained();

    // Random phases: mostly well-formed cadences, some noise
    total = 0;
    while (total < 650) begin
      int before_n;
      random_config();
      before_n = pending_ticks.size();
      push_tick(1'b1, V_NEITHER);
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < 30; i++)
          push_tick($urandom_range(0, 15) == 0, 2'($urandom_range(0, 3)));
      end else begin
        push_cadence($urandom_range(2, 18), $urandom_range(1, 6), $urandom_range(1, 8),
          $urandom_range(0, 2));
      end
      total += pending_ticks.size() - before_n;
      if ($urandom_range(0, 4) == 0) hold_off = $urandom_range(50, 150);
      wait_drained();
    end

    if (n_errors == 0)
      $display("tone_cadence_matcher_top_test: clean");
    else
      $display("tone_cadence_matcher_top_test: errors");
    $finish;
  end
endmodule
